>>> src/stt_pkg.sv
package stt_pkg;

  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChApos    = 8'h27;
  localparam logic [7:0] ChBslash  = 8'h5c;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChLbrack  = 8'h5b;
  localparam logic [7:0] ChRbrack  = 8'h5d;
  localparam logic [7:0] ChLf      = 8'h0a;
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChBs      = 8'h08;
  localparam logic [7:0] ChFf      = 8'h0c;
  localparam logic [7:0] ChLowB    = 8'h62;
  localparam logic [7:0] ChLowF    = 8'h66;
  localparam logic [7:0] ChLowN    = 8'h6e;
  localparam logic [7:0] ChLowR    = 8'h72;
  localparam logic [7:0] ChLowT    = 8'h74;

  // output queue depth; must be a power of two and at least 4
  localparam int unsigned OutDepth = 4;

  typedef enum logic [1:0] {
    ErrNone     = 2'd0,
    ErrEscape   = 2'd1,
    ErrNewline  = 2'd2,
    ErrUnterm   = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0] tok_byte;
    logic       has_byte;
    logic       tok_first;
    logic       tok_last;
    logic [1:0] err_code;
  } tok_t;

  // results of one lexed byte: cnt words, res0 goes out first
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       res0;
    tok_t       res1;
  } lex_res_t;

endpackage

>>> src/stt_if.sv
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface stt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tok_byte;
  logic       has_byte;
  logic       tok_first;
  logic       tok_last;
  logic [1:0] err_code;

  modport source (output valid, output tok_byte, output has_byte, output tok_first,
                  output tok_last, output err_code, input ready);
  modport sink   (input valid, input tok_byte, input has_byte, input tok_first,
                  input tok_last, input err_code, output ready);
endinterface

>>> src/stt_lexer.sv
module stt_lexer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       ch_i,
  input  logic             last_i,
  output stt_pkg::lex_res_t res_o
);

  typedef enum logic [2:0] {
    MIdle    = 3'd0,
    MBare    = 3'd1,
    MQuoted  = 3'd2,
    MEscape  = 3'd3,
    MComment = 3'd4,
    MError   = 3'd5
  } mode_e;

  mode_e mode_q, mode_d;

  logic          ws, term;
  logic          idle_emit;
  stt_pkg::tok_t idle_res;
  mode_e         idle_mode;
  logic          esc_ok;
  logic [7:0]    esc_ch;

  function automatic stt_pkg::tok_t mk(logic [7:0] b, logic has, logic first,
                                       logic lst, stt_pkg::err_e err);
    stt_pkg::tok_t t;
    t.tok_byte  = b;
    t.has_byte  = has;
    t.tok_first = first;
    t.tok_last  = lst;
    t.err_code  = err;
    return t;
  endfunction

  assign ws   = (ch_i == stt_pkg::ChSpace) || (ch_i >= stt_pkg::ChTab && ch_i <= stt_pkg::ChCr);
  assign term = ws || ch_i == stt_pkg::ChQuote || ch_i == stt_pkg::ChLbrack
                || ch_i == stt_pkg::ChRbrack;

  // token start, also used for the byte that ends a bare word
  always_comb begin
    idle_emit = 1'b0;
    idle_res  = mk(ch_i, 1'b1, 1'b1, last_i, stt_pkg::ErrNone);
    idle_mode = MIdle;
    if (ws) begin
      idle_mode = MIdle;
    end else if (ch_i == stt_pkg::ChQuote) begin
      idle_emit = 1'b1;
      idle_res  = mk(ch_i, 1'b1, 1'b1, last_i,
                     last_i ? stt_pkg::ErrUnterm : stt_pkg::ErrNone);
      idle_mode = last_i ? MIdle : MQuoted;
    end else if (ch_i == stt_pkg::ChLbrack || ch_i == stt_pkg::ChRbrack) begin
      idle_emit = 1'b1;
      idle_res  = mk(ch_i, 1'b1, 1'b1, 1'b1, stt_pkg::ErrNone);
    end else if (ch_i == stt_pkg::ChHash) begin
      idle_mode = last_i ? MIdle : MComment;
    end else begin
      idle_emit = 1'b1;
      idle_mode = last_i ? MIdle : MBare;
    end
  end

  always_comb begin
    esc_ok = 1'b1;
    case (ch_i)
      stt_pkg::ChLowB:   esc_ch = stt_pkg::ChBs;
      stt_pkg::ChLowF:   esc_ch = stt_pkg::ChFf;
      stt_pkg::ChLowN:   esc_ch = stt_pkg::ChLf;
      stt_pkg::ChLowR:   esc_ch = stt_pkg::ChCr;
      stt_pkg::ChLowT:   esc_ch = stt_pkg::ChTab;
      stt_pkg::ChBslash: esc_ch = stt_pkg::ChBslash;
      stt_pkg::ChApos:   esc_ch = stt_pkg::ChApos;
      stt_pkg::ChQuote:  esc_ch = stt_pkg::ChQuote;
      default: begin
        esc_ch = 8'h00;
        esc_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_o.cnt  = 2'd0;
    res_o.res0 = idle_res;
    res_o.res1 = idle_res;
    mode_d     = mode_q;
    case (mode_q)
      MBare: begin
        if (term) begin
          res_o.res0 = mk(8'h00, 1'b0, 1'b0, 1'b1, stt_pkg::ErrNone);
          res_o.cnt  = idle_emit ? 2'd2 : 2'd1;
          mode_d     = idle_mode;
        end else begin
          res_o.res0 = mk(ch_i, 1'b1, 1'b0, last_i, stt_pkg::ErrNone);
          res_o.cnt  = 2'd1;
          mode_d     = last_i ? MIdle : MBare;
        end
      end
      MQuoted: begin
        if (ch_i == stt_pkg::ChQuote) begin
          res_o.res0 = mk(ch_i, 1'b1, 1'b0, 1'b1, stt_pkg::ErrNone);
          res_o.cnt  = 2'd1;
          mode_d     = MIdle;
        end else if (ch_i == stt_pkg::ChLf) begin
          res_o.res0 = mk(8'h00, 1'b0, 1'b0, 1'b1, stt_pkg::ErrNewline);
          res_o.cnt  = 2'd1;
          mode_d     = last_i ? MIdle : MError;
        end else if (ch_i == stt_pkg::ChBslash) begin
          res_o.res0 = mk(8'h00, 1'b0, 1'b0, 1'b1, stt_pkg::ErrUnterm);
          res_o.cnt  = last_i ? 2'd1 : 2'd0;
          mode_d     = last_i ? MIdle : MEscape;
        end else begin
          res_o.res0 = mk(ch_i, 1'b1, 1'b0, last_i,
                          last_i ? stt_pkg::ErrUnterm : stt_pkg::ErrNone);
          res_o.cnt  = 2'd1;
          mode_d     = last_i ? MIdle : MQuoted;
        end
      end
      MEscape: begin
        res_o.cnt = 2'd1;
        if (last_i) begin
          res_o.res0 = mk(esc_ch, esc_ok, 1'b0, 1'b1, stt_pkg::ErrUnterm);
          mode_d     = MIdle;
        end else if (esc_ok) begin
          res_o.res0 = mk(esc_ch, 1'b1, 1'b0, 1'b0, stt_pkg::ErrNone);
          mode_d     = MQuoted;
        end else begin
          res_o.res0 = mk(8'h00, 1'b0, 1'b0, 1'b1, stt_pkg::ErrEscape);
          mode_d     = MError;
        end
      end
      MComment: begin
        if (last_i || ch_i == stt_pkg::ChCr || ch_i == stt_pkg::ChLf) begin
          mode_d = MIdle;
        end
      end
      MError: begin
        if (last_i) begin
          mode_d = MIdle;
        end
      end
      default: begin
        res_o.res0 = idle_res;
        res_o.cnt  = idle_emit ? 2'd1 : 2'd0;
        mode_d     = idle_mode;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle;
    end else if (step_i) begin
      mode_q <= mode_d;
    end
  end

endmodule

>>> src/stt_out_fifo.sv
module stt_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  stt_pkg::lex_res_t res_i,
  output logic              room_o,
  stt_out_if.source         out_o
);

  localparam int unsigned PtrW = $clog2(stt_pkg::OutDepth);
  localparam int unsigned CntW = PtrW + 1;

  stt_pkg::tok_t mem_q [stt_pkg::OutDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_nxt;
  logic [CntW-1:0] cnt_q, cnt_d, n_push;
  logic            pop;
  stt_pkg::tok_t   head;

  assign n_push = push_i ? CntW'(res_i.cnt) : '0;
  assign pop    = out_o.valid && out_o.ready;
  assign wr_nxt = wr_ptr_q + PtrW'(1);
  // room for a full pair of words regardless of what leaves this cycle
  assign room_o = cnt_q <= CntW'(stt_pkg::OutDepth - 2);

  assign wr_ptr_d = wr_ptr_q + n_push[PtrW-1:0];
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign cnt_d    = cnt_q + n_push - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != '0) begin
      mem_q[wr_ptr_q] <= res_i.res0;
    end
    if (n_push == CntW'(2)) begin
      mem_q[wr_nxt] <= res_i.res1;
    end
  end

  assign head            = mem_q[rd_ptr_q];
  assign out_o.valid     = cnt_q != '0;
  assign out_o.tok_byte  = head.tok_byte;
  assign out_o.has_byte  = head.has_byte;
  assign out_o.tok_first = head.tok_first;
  assign out_o.tok_last  = head.tok_last;
  assign out_o.err_code  = head.err_code;

endmodule

>>> src/scene_text_tokenizer.sv
// channel   dir   words                                            handshake
// in_i      in    in_byte, is_last                                 valid/ready
// out_o     out   tok_byte, has_byte, tok_first, tok_last, err_code valid/ready
//
// One byte accepted per cycle while the queue has room; each byte gives
// zero, one or two words. A byte is held in the input register, decoded by
// the lexer and pushed into a four-word output queue, from whose head the
// words are offered. The queue takes a byte only with room for two words, so
// with a free-running sink two-word bytes stall in_i once the queue has filled.
// Reset (rst_ni low, asynchronous) puts the lexer in idle and empties the queue.
// Output stalls back up through the queue to in_i.ready.
module scene_text_tokenizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);

  logic              s1_valid_q;
  logic [7:0]        s1_ch_q;
  logic              s1_last_q;
  logic              room, adv;
  stt_pkg::lex_res_t lex_res;

  assign adv        = s1_valid_q && room;
  assign in_i.ready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_ch_q   <= in_i.in_byte;
      s1_last_q <= in_i.is_last;
    end
  end

  stt_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .ch_i   (s1_ch_q),
    .last_i (s1_last_q),
    .res_o  (lex_res)
  );

  stt_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (adv),
    .res_i  (lex_res),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

  typedef enum logic [2:0] {
    LxIdle,
    LxBare,
    LxQuoted,
    LxEscape,
    LxComment,
    LxError
  } lx_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  logic clk_i;
  logic rst_ni;

  stt_in_if  in_if ();
  stt_out_if out_if ();

  scene_text_tokenizer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  text_byte_t     text_q[$];
  stt_pkg::tok_t  tok_q[$];
  lx_mode_e       lx_mode;
  text_byte_t     cur;
  stt_pkg::tok_t  want;

  int n_fail      = 0;
  int n_sent      = 0;
  int n_words     = 0;
  int n_err_marks = 0;

  bit in_busy, in_taken, in_calm;
  int in_wait = 0;
  bit out_taken, out_calm, hold_off;
  int out_wait = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- lexer model

  function automatic bit is_space(logic [7:0] c);
    return c == stt_pkg::ChSpace || (c >= stt_pkg::ChTab && c <= stt_pkg::ChCr);
  endfunction

  function automatic void push_tok(logic [7:0] b, logic has, logic first, logic last,
                                   stt_pkg::err_e err);
    stt_pkg::tok_t t;
    t.tok_byte  = b;
    t.has_byte  = has;
    t.tok_first = first;
    t.tok_last  = last;
    t.err_code  = err;
    tok_q.push_back(t);
  endfunction

  // byte seen with no token open
  function automatic void lex_fresh(logic [7:0] c, logic last);
    if (is_space(c)) begin
      lx_mode = LxIdle;
    end else if (c == stt_pkg::ChQuote) begin
      if (last) begin
        push_tok(c, 1'b1, 1'b1, 1'b1, stt_pkg::ErrUnterm);
        lx_mode = LxIdle;
      end else begin
        push_tok(c, 1'b1, 1'b1, 1'b0, stt_pkg::ErrNone);
        lx_mode = LxQuoted;
      end
    end else if (c == stt_pkg::ChLbrack || c == stt_pkg::ChRbrack) begin
      push_tok(c, 1'b1, 1'b1, 1'b1, stt_pkg::ErrNone);
      lx_mode = LxIdle;
    end else if (c == stt_pkg::ChHash) begin
      lx_mode = last ? LxIdle : LxComment;
    end else begin
      push_tok(c, 1'b1, 1'b1, last, stt_pkg::ErrNone);
      lx_mode = last ? LxIdle : LxBare;
    end
  endfunction

  function automatic bit unescape(logic [7:0] c, output logic [7:0] d);
    d = 8'h00;
    case (c)
      stt_pkg::ChLowB: d = stt_pkg::ChBs;
      stt_pkg::ChLowF: d = stt_pkg::ChFf;
      stt_pkg::ChLowN: d = stt_pkg::ChLf;
      stt_pkg::ChLowR: d = stt_pkg::ChCr;
      stt_pkg::ChLowT: d = stt_pkg::ChTab;
      stt_pkg::ChBslash, stt_pkg::ChApos, stt_pkg::ChQuote: d = c;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void lex_byte(logic [7:0] c, logic last);
    logic [7:0] d;
    bit         ok;
    case (lx_mode)
      LxBare: begin
        if (is_space(c) || c == stt_pkg::ChQuote || c == stt_pkg::ChLbrack ||
            c == stt_pkg::ChRbrack) begin
          push_tok(8'h00, 1'b0, 1'b0, 1'b1, stt_pkg::ErrNone);
          lex_fresh(c, last);
        end else begin
          push_tok(c, 1'b1, 1'b0, last, stt_pkg::ErrNone);
          lx_mode = last ? LxIdle : LxBare;
        end
      end
      LxQuoted: begin
        if (c == stt_pkg::ChQuote) begin
          push_tok(c, 1'b1, 1'b0, 1'b1, stt_pkg::ErrNone);
          lx_mode = LxIdle;
        end else if (c == stt_pkg::ChLf) begin
          push_tok(8'h00, 1'b0, 1'b0, 1'b1, stt_pkg::ErrNewline);
          lx_mode = last ? LxIdle : LxError;
        end else if (c == stt_pkg::ChBslash) begin
          if (last) begin
            push_tok(8'h00, 1'b0, 1'b0, 1'b1, stt_pkg::ErrUnterm);
            lx_mode = LxIdle;
          end else begin
            lx_mode = LxEscape;
          end
        end else if (last) begin
          push_tok(c, 1'b1, 1'b0, 1'b1, stt_pkg::ErrUnterm);
          lx_mode = LxIdle;
        end else begin
          push_tok(c, 1'b1, 1'b0, 1'b0, stt_pkg::ErrNone);
        end
      end
      LxEscape: begin
        ok = unescape(c, d);
        if (last) begin
          if (ok) push_tok(d, 1'b1, 1'b0, 1'b1, stt_pkg::ErrUnterm);
          else push_tok(8'h00, 1'b0, 1'b0, 1'b1, stt_pkg::ErrUnterm);
          lx_mode = LxIdle;
        end else if (ok) begin
          push_tok(d, 1'b1, 1'b0, 1'b0, stt_pkg::ErrNone);
          lx_mode = LxQuoted;
        end else begin
          push_tok(8'h00, 1'b0, 1'b0, 1'b1, stt_pkg::ErrEscape);
          lx_mode = LxError;
        end
      end
      LxComment: begin
        if (last || c == stt_pkg::ChCr || c == stt_pkg::ChLf) lx_mode = LxIdle;
      end
      LxError: begin
        if (last) lx_mode = LxIdle;
      end
      default: lex_fresh(c, last);
    endcase
  endfunction

  // ---------------------------------------------------------------- text builder

  function automatic void add(logic [7:0] c, logic last = 1'b0);
    text_byte_t t;
    t.ch   = c;
    t.last = last;
    text_q.push_back(t);
  endfunction

  function automatic logic [7:0] word_char(bit lead);
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(33, 126));
    end while (is_space(c) || c == stt_pkg::ChQuote || c == stt_pkg::ChLbrack ||
               c == stt_pkg::ChRbrack || (lead && c == stt_pkg::ChHash));
    return c;
  endfunction

  // anything that neither closes a string nor starts an escape nor breaks it
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(32, 126));
    end while (c == stt_pkg::ChQuote || c == stt_pkg::ChBslash || c == stt_pkg::ChLf);
    return c;
  endfunction

  function automatic logic [7:0] escape_char();
    case ($urandom_range(0, 7))
      0: return stt_pkg::ChLowB;
      1: return stt_pkg::ChLowF;
      2: return stt_pkg::ChLowN;
      3: return stt_pkg::ChLowR;
      4: return stt_pkg::ChLowT;
      5: return stt_pkg::ChBslash;
      6: return stt_pkg::ChApos;
      default: return stt_pkg::ChQuote;
    endcase
  endfunction

  function automatic logic [7:0] space_char();
    return ($urandom_range(0, 2) == 0) ? stt_pkg::ChSpace
                                       : 8'($urandom_range(stt_pkg::ChTab, stt_pkg::ChCr));
  endfunction

  // one text: a handful of tokens, mostly well formed, last byte marked
  function automatic void gen_text();
    int         n_tok;
    int         len;
    logic [7:0] txt[$];
    n_tok = $urandom_range(1, 6);
    for (int i = 0; i < n_tok; i++) begin
      case ($urandom_range(0, 11))
        0, 1, 2: begin
          len = $urandom_range(1, 6);
          txt.push_back(word_char(1'b1));
          for (int j = 1; j < len; j++) txt.push_back(word_char(1'b0));
        end
        3, 4, 5: begin
          txt.push_back(stt_pkg::ChQuote);
          len = $urandom_range(0, 6);
          for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 4) == 0) begin
              txt.push_back(stt_pkg::ChBslash);
              txt.push_back(escape_char());
            end else begin
              txt.push_back(plain_char());
            end
          end
          if ($urandom_range(0, 9) != 0) txt.push_back(stt_pkg::ChQuote);
        end
        6: txt.push_back($urandom_range(0, 1) ? stt_pkg::ChLbrack : stt_pkg::ChRbrack);
        7: begin
          txt.push_back(stt_pkg::ChHash);
          len = $urandom_range(0, 5);
          for (int j = 0; j < len; j++) txt.push_back(plain_char());
          txt.push_back($urandom_range(0, 1) ? stt_pkg::ChCr : stt_pkg::ChLf);
        end
        8: txt.push_back(8'($urandom_range(0, 255)));
        9: begin
          // broken string: newline or a doubtful escape
          txt.push_back(stt_pkg::ChQuote);
          txt.push_back(plain_char());
          if ($urandom_range(0, 1)) begin
            txt.push_back(stt_pkg::ChLf);
          end else begin
            txt.push_back(stt_pkg::ChBslash);
            txt.push_back(8'($urandom_range(0, 255)));
          end
        end
        default: begin
          len = $urandom_range(1, 3);
          for (int j = 0; j < len; j++) txt.push_back(space_char());
        end
      endcase
      if ($urandom_range(0, 9) < 7) txt.push_back(space_char());
    end
    foreach (txt[k]) add(txt[k], k == txt.size() - 1);
  endfunction

  // ---------------------------------------------------------------- driver

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_busy  = 1'b0;
        if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
        in_wait = in_calm ? 0 : $urandom_range(0, 16);
      end
      if (!in_busy) begin
        if (in_wait > 0 || text_q.size() == 0) begin
          in_if.valid <= 1'b0;
          if (in_wait > 0) in_wait--;
        end else begin
          cur = text_q.pop_front();
          in_if.valid   <= 1'b1;
          in_if.in_byte <= cur.ch;
          in_if.is_last <= cur.last;
          in_busy = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      in_taken = 1'b1;
      n_sent++;
      lex_byte(in_if.in_byte, in_if.is_last);
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
        out_wait = out_calm ? 0 : $urandom_range(0, 16);
      end
      if (hold_off || out_wait > 0) begin
        out_if.ready <= 1'b0;
        if (out_wait > 0) out_wait--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // long back-pressure so the output queue fills and in_i stalls
  initial begin
    hold_off = 1'b0;
    wait (n_sent >= 120);
    @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (200) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  function automatic void check_field(string name, logic [7:0] e, logic [7:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      n_fail++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      out_taken = 1'b1;
      n_words++;
      if (out_if.err_code != stt_pkg::ErrNone) n_err_marks++;
      if (tok_q.size() == 0) begin
        $display("%0t: word with none expected, got byte %0h has %0b first %0b last %0b err %0d",
                 $time, out_if.tok_byte, out_if.has_byte, out_if.tok_first,
                 out_if.tok_last, out_if.err_code);
        n_fail++;
      end else begin
        want = tok_q.pop_front();
        check_field("tok_byte", want.tok_byte, out_if.tok_byte);
        check_field("has_byte", 8'(want.has_byte), 8'(out_if.has_byte));
        check_field("tok_first", 8'(want.tok_first), 8'(out_if.tok_first));
        check_field("tok_last", 8'(want.tok_last), 8'(out_if.tok_last));
        check_field("err_code", 8'(want.err_code), 8'(out_if.err_code));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni        = 1'b0;
    lx_mode       = LxIdle;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.is_last = 1'b0;
    out_if.ready  = 1'b0;

    // bracket, word ended by a quote, escapes, illegal escape then drop to end
    add(stt_pkg::ChLbrack); add("x"); add(8'hff); add(stt_pkg::ChQuote); add("a");
    add(stt_pkg::ChBslash); add(stt_pkg::ChLowN); add(stt_pkg::ChQuote);
    add(stt_pkg::ChSpace);
    add(stt_pkg::ChQuote); add(stt_pkg::ChBslash); add("q"); add(stt_pkg::ChRbrack, 1'b1);
    // comment ended by CR, zero byte in a string, newline in quotes on the last byte
    add(stt_pkg::ChHash); add("c"); add(stt_pkg::ChCr); add(stt_pkg::ChQuote);
    add(8'h00); add(stt_pkg::ChLf, 1'b1);
    // quote opening on the last byte, lone backslash at the end
    add(stt_pkg::ChQuote, 1'b1);
    add(stt_pkg::ChQuote); add(stt_pkg::ChBslash, 1'b1);
    // word ended by the last byte, comment ended by the last byte
    add("k"); add(stt_pkg::ChHash, 1'b1);
    add(stt_pkg::ChHash, 1'b1);

    while (text_q.size() < 375) gen_text();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (text_q.size() == 0 && !in_busy);
    wait (tok_q.size() == 0);
    repeat (20) @(posedge clk_i);

    $display("tb: %0d bytes lexed, %0d words checked, %0d of them error marks",
             n_sent, n_words, n_err_marks);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
src/stt_pkg.sv
src/stt_if.sv
src/stt_lexer.sv
src/stt_out_fifo.sv
src/scene_text_tokenizer.sv
test/tb.sv
